/* hw/rtl/ethip_pkg.sv */
// shared types, constants and status codes for the ethernet / vlan / ipv4 header parser
// no dependencies; imported by every module of the block
`default_nettype none

package ethip_pkg;

  // ethernet types
  localparam logic [15:0] TPID_VLAN  = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;

  // header geometry in bytes
  localparam logic [6:0] ETH_HDR_LEN  = 7'd14;
  localparam logic [6:0] VLAN_TAG_LEN = 7'd4;
  localparam logic [6:0] NET_BASE_TAGGED = ETH_HDR_LEN + VLAN_TAG_LEN;
  localparam logic [7:0] IPV4_MIN_LEN = 8'd20;
  localparam logic [6:0] POS_MAX      = 7'd127;

  // ethernet type bytes
  localparam logic [6:0] POS_TYPE_HI     = 7'd12;
  localparam logic [6:0] POS_TYPE_LO     = 7'd13;
  localparam logic [6:0] POS_INNER_HI    = 7'd16;
  localparam logic [6:0] POS_INNER_LO    = 7'd17;

  // offsets inside the ipv4 header
  localparam logic [6:0] OFF_SRC_FIRST = 7'd12;
  localparam logic [6:0] OFF_SRC_LAST  = 7'd15;
  localparam logic [6:0] OFF_DST_FIRST = 7'd16;
  localparam logic [6:0] OFF_DST_LAST  = 7'd19;

  localparam logic [3:0] IP_VERSION_4 = 4'd4;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_VLAN_TRUNC  = 3'd2;
  localparam logic [2:0] ST_IPV4_TRUNC  = 3'd3;
  localparam logic [2:0] ST_BAD_VERSION = 3'd4;
  localparam logic [2:0] ST_BAD_HLEN    = 3'd5;
  localparam logic [2:0] ST_IPV6        = 3'd6;
  localparam logic [2:0] ST_UNKNOWN     = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] inner_type;
    logic        vlan_seen;
    logic [5:0]  ip_header_bytes;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } out_beat_t;

  // frame fields as they stand once the current byte has been taken in
  typedef struct packed {
    logic [6:0]  idx;
    logic [15:0] type_word;
    logic        tag_flag;
    logic [3:0]  version_nibble;
    logic [3:0]  length_nibble;
    logic [31:0] source_reg;
    logic [31:0] dest_reg;
  } frame_view_t;

endpackage

`default_nettype wire

/* hw/rtl/ethip_track.sv */
// per-frame state: byte position, ethernet type, tag flag and ipv4 header fields
// depends on ethip_pkg
`default_nettype none

module ethip_track import ethip_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire in_beat_t    beat,
  output frame_view_t      view
);

  logic [6:0]  byte_position;
  logic [15:0] type_word;
  logic        tag_flag;
  logic [3:0]  version_nibble;
  logic [3:0]  length_nibble;
  logic [31:0] source_reg;
  logic [31:0] dest_reg;

  logic [15:0] type_mid;
  logic        tag_next;
  logic [15:0] type_next;
  logic [6:0]  base;
  logic [6:0]  off;
  logic        in_net;
  logic [3:0]  version_next;
  logic [3:0]  length_next;
  logic [31:0] source_next;
  logic [31:0] dest_next;
  logic [6:0]  byte_position_next;

  always_comb begin
    type_mid = type_word;
    if (byte_position == POS_TYPE_HI || byte_position == POS_TYPE_LO) begin
      type_mid = {type_word[7:0], beat.data_byte};
    end
    tag_next = tag_flag || (byte_position == POS_TYPE_LO && type_mid == TPID_VLAN);
    type_next = type_mid;
    if (tag_next && (byte_position == POS_INNER_HI || byte_position == POS_INNER_LO)) begin
      type_next = {type_mid[7:0], beat.data_byte};
    end

    base   = tag_next ? NET_BASE_TAGGED : ETH_HDR_LEN;
    in_net = byte_position >= base;
    off    = byte_position - base;

    version_next = version_nibble;
    length_next  = length_nibble;
    source_next  = source_reg;
    dest_next    = dest_reg;
    if (in_net) begin
      if (off == '0) begin
        version_next = beat.data_byte[7:4];
        length_next  = beat.data_byte[3:0];
      end else if (off >= OFF_SRC_FIRST && off <= OFF_SRC_LAST) begin
        source_next = {source_reg[23:0], beat.data_byte};
      end else if (off >= OFF_DST_FIRST && off <= OFF_DST_LAST) begin
        dest_next = {dest_reg[23:0], beat.data_byte};
      end
    end

    byte_position_next = (byte_position == POS_MAX) ? byte_position : byte_position + 7'd1;
  end

  assign view = '{
    idx:            byte_position,
    type_word:      type_next,
    tag_flag:       tag_next,
    version_nibble: version_next,
    length_nibble:  length_next,
    source_reg:     source_next,
    dest_reg:       dest_next
  };

  // frame state clears after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      type_word      <= '0;
      tag_flag       <= 1'b0;
      version_nibble <= '0;
      length_nibble  <= '0;
      source_reg     <= '0;
      dest_reg       <= '0;
    end else if (advance) begin
      if (beat.last_byte) begin
        byte_position  <= '0;
        type_word      <= '0;
        tag_flag       <= 1'b0;
        version_nibble <= '0;
        length_nibble  <= '0;
        source_reg     <= '0;
        dest_reg       <= '0;
      end else begin
        byte_position  <= byte_position_next;
        type_word      <= type_next;
        tag_flag       <= tag_next;
        version_nibble <= version_next;
        length_nibble  <= length_next;
        source_reg     <= source_next;
        dest_reg       <= dest_next;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ethip_classify.sv */
// end-of-frame checks: status code and result fields from the frame view
// depends on ethip_pkg
`default_nettype none

module ethip_classify import ethip_pkg::*; (
  input  frame_view_t view,
  output out_beat_t   res
);

  logic [7:0] frame_len;
  logic [7:0] base;
  logic [7:0] net_len;
  logic [5:0] hlen;

  assign frame_len = {1'b0, view.idx} + 8'd1;
  assign base      = view.tag_flag ? {1'b0, NET_BASE_TAGGED} : {1'b0, ETH_HDR_LEN};
  assign net_len   = frame_len - base;
  assign hlen      = {view.length_nibble, 2'b00};

  always_comb begin
    res = '0;
    if (frame_len < {1'b0, ETH_HDR_LEN}) begin
      res.status = ST_SHORT;
    end else if (view.tag_flag && frame_len < {1'b0, NET_BASE_TAGGED}) begin
      res.status    = ST_VLAN_TRUNC;
      res.vlan_seen = 1'b1;
    end else begin
      res.vlan_seen  = view.tag_flag;
      res.inner_type = view.type_word;
      if (view.type_word == ETYPE_IPV4) begin
        if (net_len < IPV4_MIN_LEN) begin
          res.status = ST_IPV4_TRUNC;
        end else begin
          res.ip_header_bytes = hlen;
          res.source_address  = view.source_reg;
          res.dest_address    = view.dest_reg;
          if (view.version_nibble != IP_VERSION_4) begin
            res.status = ST_BAD_VERSION;
          end else if ({2'b00, hlen} < IPV4_MIN_LEN || {2'b00, hlen} > net_len) begin
            res.status = ST_BAD_HLEN;
          end else begin
            res.status = ST_OK;
          end
        end
      end else if (view.type_word == ETYPE_IPV6) begin
        res.status = ST_IPV6;
      end else begin
        res.status = ST_UNKNOWN;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ethernet_ipv4_header_parser_top.sv */
// top level of the ethernet / vlan / ipv4 header parser: input register, frame
// state, end-of-frame checks and result register; depends on ethip_pkg,
// ethip_track and ethip_classify
//
// usage
//  - frame channel: one frame byte per beat, in wire order, last_byte on the
//    final beat of each frame; a beat is taken when frame_valid is high and
//    frame_stall is low
//  - result channel: one beat per frame, issued for the beat marked last_byte,
//    carrying the first failed check (or ok), inner type, vlan flag, ipv4
//    header length and addresses; fields not reached read as zero
//  - path: a last beat passes through the input register, then the result
//    register, before its result beat is valid
//  - throughput: one byte per cycle while no waiting result is held by
//    result_stall; the whole per-byte update and the end-of-frame checks sit
//    in one short logic stage between the two registers
//  - stall: while result_stall holds a waiting result, the input register
//    holds too and frame_stall rises once it is full; no beat is lost
//  - reset: synchronous rst empties both registers and clears the frame
//    state, so the next byte is taken as byte 0 of a new frame
`default_nettype none

module ethernet_ipv4_header_parser_top import ethip_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      frame_valid,
  output logic           frame_stall,
  input  wire in_beat_t  frame,
  output logic           result_valid,
  input  wire logic      result_stall,
  output out_beat_t      result
);

  // input register
  logic        s1_valid;
  in_beat_t    s1_beat;

  // handshake control
  logic        out_free;
  logic        s1_advance;
  logic        in_ready;

  frame_view_t view;
  out_beat_t   res;

  // the result register can take a new beat when empty or being drained
  assign out_free    = !result_valid || !result_stall;
  assign s1_advance  = s1_valid && out_free;
  assign in_ready    = !s1_valid || s1_advance;
  assign frame_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= frame_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && frame_valid) begin
      s1_beat <= frame;
    end
  end

  ethip_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .beat    (s1_beat),
    .view    (view)
  );

  ethip_classify u_classify (
    .view (view),
    .res  (res)
  );

  // result register: loaded only from the last byte of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_advance && s1_beat.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_advance && s1_beat.last_byte) begin
      result <= res;
    end
  end

  // a fresh result only ever follows a last byte in the input register
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid && s1_beat.last_byte))
    else $error("result issued without a last byte");

  // a held input register keeps its beat while the result side is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_beat)))
    else $error("input register lost a beat under stall");

  // an ok result is ipv4 with a legal header length
  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_OK) |->
      (result.inner_type == ETYPE_IPV4 && {2'b00, result.ip_header_bytes} >= IPV4_MIN_LEN))
    else $error("ok status with bad ipv4 fields");

  // a short frame reaches no field
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_SHORT) |->
      (result.inner_type == '0 && !result.vlan_seen && result.ip_header_bytes == '0 &&
       result.source_address == '0 && result.dest_address == '0))
    else $error("short frame result carries field data");

endmodule

`default_nettype wire
